[rtl/ecrm_pkg.sv]
// Shared types and constants for the EWMA counter rate meter.
// Holds the word layouts, command and status codes and arithmetic widths.
// No dependencies; every other file imports this package.
package ecrm_pkg;

  // Field widths of the input and result words.
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 63;
  localparam int TIME_W   = 48;
  localparam int MEAN_W   = 64;
  localparam int STATUS_W = 3;
  localparam int WEIGHT_W = 17;

  // Default table size.
  localparam int SLOT_COUNT_DEF = 64;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INIT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INIT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_TIME = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNUSED  = 3'd4;

  // Smoothing weight: reset value and the Q0.16 value of one.
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd6554;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;

  // Microseconds per second, the rate scale factor.
  localparam int RATE_SCALE_W = 20;
  localparam logic [RATE_SCALE_W-1:0] RATE_SCALE = 20'd1000000;

  // Accumulator width: counter delta times the scale, shifted by 16 bits.
  localparam int ACC_W = COUNT_W + RATE_SCALE_W + 16;

  // Q47.16 limits.
  localparam logic [MEAN_W-1:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [MEAN_W-1:0] Q_MIN = 64'h8000_0000_0000_0000;

  // Input word.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count_value;
    logic [TIME_W-1:0]  time_us;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [SLOT_W-1:0]        slot_out;
    logic signed [MEAN_W-1:0] mean_rate;
    logic [STATUS_W-1:0]      status;
    logic                     saturated;
  } out_word_t;

  // Operands handed to the arithmetic unit for one sample.
  typedef struct packed {
    logic [COUNT_W-1:0]  count_now;
    logic [COUNT_W-1:0]  count_last;
    logic [TIME_W-1:0]   time_now;
    logic [TIME_W-1:0]   time_last;
    logic [MEAN_W-1:0]   mean_last;
    logic [WEIGHT_W-1:0] weight;
  } ecrm_job_t;

  // Outcome of one sample from the arithmetic unit.
  typedef struct packed {
    logic              elapsed;
    logic [MEAN_W-1:0] mean;
    logic              saturated;
  } ecrm_res_t;

endpackage

[rtl/ewma_counter_rate_meter.sv]
// Channel   Signals                         Word        Accepted when
// input     in_valid / in_ready / in_data   in_word_t   in_valid && in_ready
// output    out_valid / out_ready / out_data out_word_t out_valid && out_ready
// config    cfg_write / cfg_data            17 bits     cfg_write
//
// An updating sample raises out_valid after 20 scaling, 99 divide and 17 blend
// steps on the shared adder in ecrm_arith, plus negation of the delta when the
// counter went backwards. Init, remove and refused words bypass ecrm_arith; a sample with
// no elapsed time stops after the time delta. One word at a time; in_ready returns once the
// result moves into the output register, which waits while a prior result stalls.
// Reset clears the slot-in-use flags at once and restores the smoothing weight.
// Depends on ecrm_pkg and ecrm_arith.
module ewma_counter_rate_meter import ecrm_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_word_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_word_t           out_data,
  input  logic                cfg_write,
  input  logic [WEIGHT_W-1:0] cfg_data
);

  // Only slots reachable by the slot field get storage.
  localparam int MEM_DEPTH = (SLOT_COUNT < (1 << SLOT_W)) ? SLOT_COUNT : (1 << SLOT_W);
  localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_SEND = 2'd3;

  logic [1:0]          state;
  logic [WEIGHT_W-1:0] weight;
  logic [MEM_DEPTH-1:0] in_use;
  in_word_t            item;
  out_word_t           res_word;

  // Slot memories, read at acceptance and written at most once per word.
  logic [COUNT_W-1:0] mem_count [MEM_DEPTH];
  logic [TIME_W-1:0]  mem_time  [MEM_DEPTH];
  logic [MEAN_W-1:0]  mem_mean  [MEM_DEPTH];
  logic [COUNT_W-1:0] rd_count;
  logic [TIME_W-1:0]  rd_time;
  logic [MEAN_W-1:0]  rd_mean;

  logic              accept;
  logic [IDX_W-1:0]  in_idx;
  logic [IDX_W-1:0]  idx;
  logic              in_range;
  logic              calc;
  logic              wr_en;
  logic [MEAN_W-1:0] wr_mean;
  logic              start;
  logic              done;
  ecrm_job_t         job;
  ecrm_res_t         res;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_idx   = in_data.slot[IDX_W-1:0];
  assign idx      = item.slot[IDX_W-1:0];
  assign in_range = (32'(item.slot) < 32'(SLOT_COUNT));
  assign calc     = in_range && (item.command == CMD_SAMPLE) && in_use[idx];
  assign start    = (state == S_LOOK) && calc;

  // Memory write: init stores a fresh entry, an updating sample the new one.
  assign wr_en = ((state == S_LOOK) && in_range && (item.command == CMD_INIT)) ||
                 ((state == S_CALC) && done && res.elapsed);
  assign wr_mean = (state == S_LOOK) ? '0 : res.mean;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_count[idx] <= item.count_value;
      mem_time[idx]  <= item.time_us;
      mem_mean[idx]  <= wr_mean;
    end
    if (accept) begin
      rd_count <= mem_count[in_idx];
      rd_time  <= mem_time[in_idx];
      rd_mean  <= mem_mean[in_idx];
    end
  end

  // Operands for the arithmetic unit stay stable while it runs, except the weight, which cfg_write can change.
  assign job.count_now  = item.count_value;
  assign job.count_last = rd_count;
  assign job.time_now   = item.time_us;
  assign job.time_last  = rd_time;
  assign job.mean_last  = rd_mean;
  assign job.weight     = weight;

  ecrm_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .job   (job),
    .done  (done),
    .res   (res)
  );

  // Control: sequencer, output valid, weight register and in-use flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      weight    <= WEIGHT_RESET;
      in_use    <= '0;
    end else begin
      if (cfg_write) begin
        weight <= (cfg_data > WEIGHT_ONE) ? WEIGHT_ONE : cfg_data;
      end
      if (out_valid && out_ready && state != S_SEND) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_LOOK;
        end
        S_LOOK: begin
          state <= calc ? S_CALC : S_SEND;
          if (in_range && item.command == CMD_INIT) begin
            in_use[idx] <= 1'b1;
          end
          if (in_range && item.command == CMD_REMOVE) begin
            in_use[idx] <= 1'b0;
          end
        end
        S_CALC: begin
          if (done) state <= S_SEND;
        end
        S_SEND: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload: captured word, formed result and output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (state == S_LOOK) begin
      res_word.slot_out  <= item.slot;
      res_word.mean_rate <= '0;
      res_word.saturated <= 1'b0;
      case (item.command)
        CMD_INIT:   res_word.status <= in_range ? ST_INIT : ST_UNUSED;
        CMD_REMOVE: res_word.status <= in_range ? ST_REMOVED : ST_UNUSED;
        default:    res_word.status <= ST_UNUSED;
      endcase
    end
    if (state == S_CALC && done) begin
      if (res.elapsed) begin
        res_word.mean_rate <= res.mean;
        res_word.status    <= ST_UPDATED;
        res_word.saturated <= res.saturated;
      end else begin
        res_word.mean_rate <= rd_mean;
        res_word.status    <= ST_NO_TIME;
        res_word.saturated <= 1'b0;
      end
    end
    if (state == S_SEND && (!out_valid || out_ready)) begin
      out_data <= res_word;
    end
  end

endmodule

[rtl/ecrm_arith.sv]
// Iterative arithmetic unit of the rate meter: time delta, counter delta,
// shift-add scaling, restoring divide and weighted blend on one shared adder.
// Depends on ecrm_pkg.
module ecrm_arith import ecrm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ecrm_job_t job,
  output logic      done,
  output ecrm_res_t res
);

  localparam int PH_W  = 4;
  localparam int CNT_W = $clog2(ACC_W);
  localparam int SEL_W = $clog2(RATE_SCALE_W);

  localparam logic [PH_W-1:0] P_IDLE  = 4'd0;
  localparam logic [PH_W-1:0] P_DT    = 4'd1;
  localparam logic [PH_W-1:0] P_DELTA = 4'd2;
  localparam logic [PH_W-1:0] P_ABS   = 4'd3;
  localparam logic [PH_W-1:0] P_MUL   = 4'd4;
  localparam logic [PH_W-1:0] P_DIV   = 4'd5;
  localparam logic [PH_W-1:0] P_RATE  = 4'd6;
  localparam logic [PH_W-1:0] P_DIFF  = 4'd7;
  localparam logic [PH_W-1:0] P_BLEND = 4'd8;
  localparam logic [PH_W-1:0] P_FIN   = 4'd9;
  localparam logic [PH_W-1:0] P_DONE  = 4'd10;

  logic [PH_W-1:0]    phase;
  logic [CNT_W-1:0]   cnt;
  logic [ACC_W-1:0]   acc;
  logic [TIME_W-1:0]  rem;
  logic [TIME_W-1:0]  dt;
  logic [COUNT_W-1:0] mag;
  logic [MEAN_W-1:0]  rate;
  logic [MEAN_W:0]    diff;
  logic               neg;
  logic               sat;
  logic               elapsed;

  // Shared adder and its operand selection.
  logic [ACC_W-1:0] opa;
  logic [ACC_W-1:0] opb;
  logic             sub;
  logic [ACC_W-1:0] sum;
  logic [TIME_W:0]  rem_sh;
  logic             take;
  logic             over;
  logic [MEAN_W-1:0] q_sat;
  logic             fits;
  logic [SEL_W-1:0] sel;

  assign rem_sh = {rem, acc[ACC_W-1]};
  assign sel    = cnt[SEL_W-1:0];

  // Quotient beyond the Q47.16 range; the negative side allows one more.
  assign over = (|acc[ACC_W-1:MEAN_W-1]) &&
                !(neg && (acc[ACC_W-1:MEAN_W-1] == (ACC_W-MEAN_W+1)'(1)) &&
                  (acc[MEAN_W-2:0] == '0));
  assign q_sat = over ? (neg ? Q_MIN : Q_MAX) : acc[MEAN_W-1:0];

  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    case (phase)
      P_DT: begin
        opa = ACC_W'(job.time_now);
        opb = ACC_W'(job.time_last);
        sub = 1'b1;
      end
      P_DELTA: begin
        opa = ACC_W'(job.count_now);
        opb = ACC_W'(job.count_last);
        sub = 1'b1;
      end
      P_ABS: begin
        opb = acc;
        sub = 1'b1;
      end
      P_MUL: begin
        opa = {acc[ACC_W-2:0], 1'b0};
        opb = RATE_SCALE[sel] ? ACC_W'(mag) : '0;
      end
      P_DIV: begin
        opa = ACC_W'(rem_sh);
        opb = ACC_W'(dt);
        sub = 1'b1;
      end
      P_RATE: begin
        opb = ACC_W'(q_sat);
        sub = neg;
      end
      P_DIFF: begin
        opa = {{(ACC_W-MEAN_W){job.mean_last[MEAN_W-1]}}, job.mean_last};
        opb = {{(ACC_W-MEAN_W){rate[MEAN_W-1]}}, rate};
        sub = 1'b1;
      end
      P_BLEND: begin
        opa = {acc[ACC_W-2:0], 1'b0};
        opb = job.weight[sel] ? {{(ACC_W-MEAN_W-1){diff[MEAN_W]}}, diff} : '0;
      end
      P_FIN: begin
        opa = acc;
        opb = {{(ACC_W-MEAN_W-16){rate[MEAN_W-1]}}, rate, 16'b0};
      end
      default: begin
        opa = '0;
        opb = '0;
        sub = 1'b0;
      end
    endcase
    sum = opa + (sub ? ~opb : opb) + ACC_W'(sub);
  end

  assign take = !sum[ACC_W-1];

  // The blended sum shifted right by 16 must fit a signed 64-bit word.
  assign fits = (&acc[ACC_W-1:MEAN_W+15]) || !(|acc[ACC_W-1:MEAN_W+15]);

  // Phase sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      case (phase)
        P_IDLE:  if (start) phase <= P_DT;
        P_DT:    phase <= (sum[ACC_W-1] || sum == '0) ? P_DONE : P_DELTA;
        P_DELTA: phase <= sum[ACC_W-1] ? P_ABS : P_MUL;
        P_ABS:   phase <= P_MUL;
        P_MUL:   if (cnt == '0) phase <= P_DIV;
        P_DIV:   if (cnt == '0) phase <= P_RATE;
        P_RATE:  phase <= P_DIFF;
        P_DIFF:  phase <= P_BLEND;
        P_BLEND: if (cnt == '0) phase <= P_FIN;
        P_FIN:   phase <= P_DONE;
        P_DONE:  phase <= P_IDLE;
        default: phase <= P_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (phase)
      P_DT: begin
        dt      <= sum[TIME_W-1:0];
        elapsed <= !(sum[ACC_W-1] || sum == '0);
        sat     <= 1'b0;
      end
      P_DELTA: begin
        // A negative delta is kept for negation; otherwise the product starts at zero.
        neg <= sum[ACC_W-1];
        acc <= sum[ACC_W-1] ? sum : '0;
        mag <= sum[COUNT_W-1:0];
        cnt <= CNT_W'(RATE_SCALE_W - 1);
      end
      P_ABS: begin
        mag <= sum[COUNT_W-1:0];
        acc <= '0;
      end
      P_MUL: begin
        // Last step also applies the Q16 scaling of the numerator.
        if (cnt == '0) begin
          acc <= {sum[ACC_W-17:0], 16'b0};
          cnt <= CNT_W'(ACC_W - 1);
          rem <= '0;
        end else begin
          acc <= sum;
          cnt <= cnt - 1'b1;
        end
      end
      P_DIV: begin
        rem <= take ? sum[TIME_W-1:0] : rem_sh[TIME_W-1:0];
        acc <= {acc[ACC_W-2:0], take};
        cnt <= cnt - 1'b1;
      end
      P_RATE: begin
        rate <= sum[MEAN_W-1:0];
        sat  <= over;
      end
      P_DIFF: begin
        diff <= sum[MEAN_W:0];
        acc  <= '0;
        cnt  <= CNT_W'(WEIGHT_W - 1);
      end
      P_BLEND: begin
        acc <= sum;
        cnt <= cnt - 1'b1;
      end
      P_FIN: begin
        acc <= sum;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // Result is presented during the final phase.
  assign done          = (phase == P_DONE);
  assign res.elapsed   = elapsed;
  assign res.mean      = fits ? acc[MEAN_W+15:16] : (acc[ACC_W-1] ? Q_MIN : Q_MAX);
  assign res.saturated = sat || !fits;

endmodule

[rtl/ecrm_checker.sv]
// Port-level checks for the EWMA counter rate meter, bound to the top level.
// Depends on ecrm_pkg and ewma_counter_rate_meter.
module ecrm_checker import ecrm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // A waiting result word holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // One word at a time: ready drops right after an acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // Only an updating sample can report saturation.
  a_sat_only_update: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_UPDATED |-> !out_data.saturated)
    else $error("saturation flagged outside an update");

  // Init, remove and refused words carry a zero mean.
  a_zero_mean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_INIT || out_data.status == ST_REMOVED ||
                  out_data.status == ST_UNUSED) |-> out_data.mean_rate == '0)
    else $error("nonzero mean on a word that changes no rate");

endmodule

bind ewma_counter_rate_meter ecrm_checker u_ecrm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
